// ===== hdl/bfje_pkg.sv =====
`timescale 1ns / 1ps
package bfje_pkg;

  localparam int LEN_W = 5;
  localparam logic [31:0] HASH_INIT = 32'hdeadbeef;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_BAD    = 2'd2;
  localparam logic [1:0] ST_RSVD   = 2'd3;

  localparam logic FUNC_INSERT = 1'b1;

  localparam logic [1:0] REG_KEY_BYTES   = 2'd0;
  localparam logic [1:0] REG_PROBE_COUNT = 2'd1;
  localparam logic [1:0] REG_SEED_BASE   = 2'd2;

  typedef struct packed {
    logic             insert;
    logic             bad;
    logic [3:0][31:0] key;
  } item_t;

  typedef struct packed {
    logic             start;
    logic [31:0]      seed;
    logic [LEN_W-1:0] len;
  } hash_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] value;
  } hash_rsp_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
    rotl = (x << r) | (x >> (32 - r));
  endfunction

  // key words beyond the fourth hash as zero
  function automatic logic [31:0] key_word(input logic [3:0][31:0] key,
                                           input logic [3:0] idx);
    key_word = (idx < 4'd4) ? key[idx[1:0]] : 32'd0;
  endfunction

  // keep only the low rem bytes of a word
  function automatic logic [31:0] keep_bytes(input logic [31:0] w,
                                             input logic [LEN_W-1:0] rem);
    case (rem)
      LEN_W'(0): keep_bytes = 32'd0;
      LEN_W'(1): keep_bytes = w & 32'h0000_00ff;
      LEN_W'(2): keep_bytes = w & 32'h0000_ffff;
      LEN_W'(3): keep_bytes = w & 32'h00ff_ffff;
      default:   keep_bytes = w;
    endcase
  endfunction

endpackage

// ===== hdl/bfje_front.sv =====
`timescale 1ns / 1ps
module bfje_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  logic            func,
  input  logic [7:0]      insert_flags,
  input  logic [31:0]     key_word0,
  input  logic [31:0]     key_word1,
  input  logic [31:0]     key_word2,
  input  logic [31:0]     key_word3,
  input  logic            pop,
  output logic            empty,
  output bfje_pkg::item_t head
);
  import bfje_pkg::*;

  item_t      e0, e1, incoming;
  logic [1:0] cnt;
  logic       do_push, do_pop;

  // classify: an insert with any flag set is rejected downstream
  always_comb begin
    incoming.insert = (func == FUNC_INSERT);
    incoming.bad    = (func == FUNC_INSERT) && (insert_flags != 8'd0);
    incoming.key    = {key_word3, key_word2, key_word1, key_word0};
  end

  assign full    = (cnt == 2'd2);
  assign empty   = (cnt == 2'd0);
  assign head    = e0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      if (do_push && cnt == 2'd1) e0 <= incoming;
      else e0 <= e1;
      if (do_push && cnt == 2'd2) e1 <= incoming;
    end else if (do_push) begin
      if (cnt == 2'd0) e0 <= incoming;
      else e1 <= incoming;
    end
  end

endmodule

// ===== hdl/bfje_hash.sv =====
`timescale 1ns / 1ps
module bfje_hash (
  input  logic                  clk,
  input  logic                  rst,
  input  bfje_pkg::hash_req_t   req,
  input  logic [3:0][31:0]      key,
  output bfje_pkg::hash_rsp_t   rsp
);
  import bfje_pkg::*;

  localparam logic [2:0] HS_IDLE = 3'd0;
  localparam logic [2:0] HS_LOAD = 3'd1;
  localparam logic [2:0] HS_MIXA = 3'd2;
  localparam logic [2:0] HS_MIXB = 3'd3;
  localparam logic [2:0] HS_FADD = 3'd4;
  localparam logic [2:0] HS_FINA = 3'd5;
  localparam logic [2:0] HS_FINB = 3'd6;

  logic [2:0]       state, state_next;
  logic [31:0]      a, b, c, a_next, b_next, c_next;
  logic [LEN_W-1:0] len, len_next;
  logic [1:0]       chunk, chunk_next;
  logic             done, done_next;
  logic [3:0]       widx;
  logic [31:0]      init, t_a, t_b, t_c;
  logic [LEN_W-1:0] rem0, rem1, rem2;

  assign widx = {1'b0, chunk, 1'b0} + {2'b00, chunk};
  assign init = HASH_INIT + {{(32 - LEN_W){1'b0}}, req.len} + req.seed;
  assign rem0 = len;
  assign rem1 = (len > LEN_W'(4)) ? len - LEN_W'(4) : LEN_W'(0);
  assign rem2 = (len > LEN_W'(8)) ? len - LEN_W'(8) : LEN_W'(0);

  always_comb begin
    state_next = state;
    a_next     = a;
    b_next     = b;
    c_next     = c;
    len_next   = len;
    chunk_next = chunk;
    done_next  = 1'b0;
    t_a        = a;
    t_b        = b;
    t_c        = c;
    case (state)
      HS_IDLE: begin
        if (req.start) begin
          a_next     = init;
          b_next     = init;
          c_next     = init;
          len_next   = req.len;
          chunk_next = 2'd0;
          if (req.len == LEN_W'(0)) done_next = 1'b1;
          else if (req.len > LEN_W'(12)) state_next = HS_LOAD;
          else state_next = HS_FADD;
        end
      end
      HS_LOAD: begin
        a_next     = a + key_word(key, widx);
        b_next     = b + key_word(key, widx + 4'd1);
        c_next     = c + key_word(key, widx + 4'd2);
        state_next = HS_MIXA;
      end
      HS_MIXA: begin
        t_a    = (a - c) ^ rotl(c, 4);
        t_c    = c + b;
        t_b    = (b - t_a) ^ rotl(t_a, 6);
        t_a    = t_a + t_c;
        t_c    = (t_c - t_b) ^ rotl(t_b, 8);
        t_b    = t_b + t_a;
        a_next = t_a;
        b_next = t_b;
        c_next = t_c;
        state_next = HS_MIXB;
      end
      HS_MIXB: begin
        t_a    = (a - c) ^ rotl(c, 16);
        t_c    = c + b;
        t_b    = (b - t_a) ^ rotl(t_a, 19);
        t_a    = t_a + t_c;
        t_c    = (t_c - t_b) ^ rotl(t_b, 4);
        t_b    = t_b + t_a;
        a_next = t_a;
        b_next = t_b;
        c_next = t_c;
        len_next   = len - LEN_W'(12);
        chunk_next = chunk + 2'd1;
        state_next = (len - LEN_W'(12) > LEN_W'(12)) ? HS_LOAD : HS_FADD;
      end
      HS_FADD: begin
        a_next     = a + keep_bytes(key_word(key, widx), rem0);
        b_next     = b + keep_bytes(key_word(key, widx + 4'd1), rem1);
        c_next     = c + keep_bytes(key_word(key, widx + 4'd2), rem2);
        state_next = HS_FINA;
      end
      HS_FINA: begin
        t_c    = (c ^ b) - rotl(b, 14);
        t_a    = (a ^ t_c) - rotl(t_c, 11);
        t_b    = (b ^ t_a) - rotl(t_a, 25);
        t_c    = (t_c ^ t_b) - rotl(t_b, 16);
        a_next = t_a;
        b_next = t_b;
        c_next = t_c;
        state_next = HS_FINB;
      end
      HS_FINB: begin
        t_a    = (a ^ c) - rotl(c, 4);
        t_b    = (b ^ t_a) - rotl(t_a, 14);
        t_c    = (c ^ t_b) - rotl(t_b, 24);
        a_next = t_a;
        b_next = t_b;
        c_next = t_c;
        done_next  = 1'b1;
        state_next = HS_IDLE;
      end
      default: state_next = HS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= HS_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    a     <= a_next;
    b     <= b_next;
    c     <= c_next;
    len   <= len_next;
    chunk <= chunk_next;
  end

  assign rsp.done  = done;
  assign rsp.value = c;

endmodule

// ===== hdl/bfje_back.sv =====
`timescale 1ns / 1ps
module bfje_back #(
  parameter int FILTER_BITS   = 256,
  parameter int MAX_KEY_BYTES = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [4:0]      key_bytes,
  input  logic [3:0]      probe_count,
  input  logic [31:0]     seed_base,
  input  logic            q_empty,
  input  bfje_pkg::item_t q_head,
  output logic            q_pop,
  output logic            res_empty,
  output logic [1:0]      res_status,
  input  logic            res_pop
);
  import bfje_pkg::*;

  localparam int WORDS = FILTER_BITS / 64;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

  localparam logic [2:0] BS_CLEAR = 3'd0;
  localparam logic [2:0] BS_IDLE  = 3'd1;
  localparam logic [2:0] BS_HASH  = 3'd2;
  localparam logic [2:0] BS_WAIT  = 3'd3;
  localparam logic [2:0] BS_CHECK = 3'd4;
  localparam logic [2:0] BS_EMIT  = 3'd5;

  logic [2:0]       state;
  item_t            item;
  logic [3:0]       probe;
  logic [1:0]       status_r;
  logic [AW-1:0]    addr_r, clr_addr, rd_addr;
  logic [5:0]       pos_r;
  logic [63:0]      mem [WORDS];
  logic [63:0]      rdata;
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic [63:0]      mem_wd;
  logic [LEN_W-1:0] len_c;
  hash_req_t        hreq;
  hash_rsp_t        hrsp;
  logic [1:0]       ocnt;
  logic [1:0]       o0, o1;
  logic             o_push, o_pop, hit, last;

  assign len_c = ({27'd0, key_bytes} > 32'(MAX_KEY_BYTES)) ? LEN_W'(MAX_KEY_BYTES)
                                                           : key_bytes;

  assign hreq.start = (state == BS_HASH);
  assign hreq.seed  = seed_base + {28'd0, probe};
  assign hreq.len   = len_c;

  bfje_hash u_hash (
    .clk (clk),
    .rst (rst),
    .req (hreq),
    .key (item.key),
    .rsp (hrsp)
  );

  assign rd_addr = hrsp.value[6 +: AW] & AW'(WORDS - 1);
  assign hit     = rdata[pos_r];
  assign last    = (probe == probe_count - 4'd1);
  assign q_pop   = (state == BS_IDLE) && !q_empty && (ocnt != 2'd2);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = addr_r;
    mem_wd = rdata | (64'd1 << pos_r);
    if (state == BS_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_addr;
      mem_wd = 64'd0;
    end else if (state == BS_CHECK && item.insert) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (state == BS_WAIT && hrsp.done) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BS_CLEAR;
      clr_addr <= '0;
    end else begin
      case (state)
        BS_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(WORDS - 1)) state <= BS_IDLE;
        end
        BS_IDLE: begin
          if (q_pop) begin
            if (q_head.bad) begin
              status_r <= ST_BAD;
              state    <= BS_EMIT;
            end else if (probe_count == 4'd0) begin
              status_r <= ST_OK;
              state    <= BS_EMIT;
            end else begin
              state <= BS_HASH;
            end
          end
        end
        BS_HASH: state <= BS_WAIT;
        BS_WAIT: begin
          if (hrsp.done) state <= BS_CHECK;
        end
        BS_CHECK: begin
          if (!item.insert && !hit) begin
            status_r <= ST_ABSENT;
            state    <= BS_EMIT;
          end else if (last) begin
            status_r <= ST_OK;
            state    <= BS_EMIT;
          end else begin
            state <= BS_HASH;
          end
        end
        BS_EMIT: state <= BS_IDLE;
        default: state <= BS_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item  <= q_head;
      probe <= 4'd0;
    end
    if (state == BS_CHECK) probe <= probe + 4'd1;
    if (state == BS_WAIT && hrsp.done) begin
      addr_r <= rd_addr;
      pos_r  <= hrsp.value[5:0];
    end
  end

  // result queue, two entries
  assign o_push     = (state == BS_EMIT);
  assign o_pop      = res_pop && (ocnt != 2'd0);
  assign res_empty  = (ocnt == 2'd0);
  assign res_status = o0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ocnt <= 2'd0;
    end else begin
      ocnt <= ocnt + {1'b0, o_push} - {1'b0, o_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (o_pop) begin
      if (o_push && ocnt == 2'd1) o0 <= status_r;
      else o0 <= o1;
      if (o_push && ocnt == 2'd2) o1 <= status_r;
    end else if (o_push) begin
      if (ocnt == 2'd0) o0 <= status_r;
      else o1 <= status_r;
    end
  end

endmodule

// ===== hdl/bloom_filter_jhash_engine_core.sv =====
`timescale 1ns / 1ps
// bloom filter engine with a jenkins hash over a FILTER_BITS-bit store
// input channel: push/full, one transaction carries func, insert_flags and
//   four little-endian key words; a transaction is taken when push && !full
// result channel: empty/pop, status of the oldest finished item sits on
//   status while empty is low; taken when pop && !empty
// config: apb-style port, key_bytes at 0x0, probe_count at 0x4,
//   seed_base at 0x8; write only while the engine is idle
// processing: the input queue, then per probe a start state, the hash
//   pass (none for an empty key, a final add and two final steps for keys
//   up to 12 bytes, plus a load and two mix steps per extra 12-byte block),
//   a memory read and a check, then the status is posted;
//   queries stop at the first clear bit
// throughput: one item at a time in the back end, set by the hash unit;
//   the two-entry input queue keeps accepting while the back end works
// reset: the store is swept to zero one 64-bit word per cycle, all
//   FILTER_BITS/64 words, before the first item is processed; registers
//   return to key_bytes 4, probe_count 5, seed_base 0
// stall: a two-entry result queue holds finished status; when it is full
//   the back end waits and the input queue fills and raises full
module bloom_filter_jhash_engine_core #(
  parameter int FILTER_BITS   = 256,
  parameter int MAX_KEY_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic        func,
  input  logic [7:0]  insert_flags,
  input  logic [31:0] key_word0,
  input  logic [31:0] key_word1,
  input  logic [31:0] key_word2,
  input  logic [31:0] key_word3,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status
);
  import bfje_pkg::*;

  logic [4:0]  key_bytes;
  logic [3:0]  probe_count;
  logic [31:0] seed_base;
  logic        cfg_wr;
  logic        q_empty, q_pop;
  item_t       q_head;

  // config registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_bytes   <= 5'd4;
      probe_count <= 4'd5;
      seed_base   <= 32'd0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_KEY_BYTES:   key_bytes   <= pwdata[4:0];
        REG_PROBE_COUNT: probe_count <= pwdata[3:0];
        REG_SEED_BASE:   seed_base   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_KEY_BYTES:   prdata = {27'd0, key_bytes};
      REG_PROBE_COUNT: prdata = {28'd0, probe_count};
      REG_SEED_BASE:   prdata = seed_base;
      default:         prdata = 32'd0;
    endcase
  end

  // front end: takes and classifies items
  bfje_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .func         (func),
    .insert_flags (insert_flags),
    .key_word0    (key_word0),
    .key_word1    (key_word1),
    .key_word2    (key_word2),
    .key_word3    (key_word3),
    .pop          (q_pop),
    .empty        (q_empty),
    .head         (q_head)
  );

  // back end: hashing, store access, result queue
  bfje_back #(
    .FILTER_BITS   (FILTER_BITS),
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .key_bytes   (key_bytes),
    .probe_count (probe_count),
    .seed_base   (seed_base),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .res_empty   (empty),
    .res_status  (status),
    .res_pop     (pop)
  );

  // no result appears right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  // only defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> status != ST_RSVD)
    else $error("reserved status code");

  // back end only drains the input queue when it holds something
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("pop from empty input queue");

endmodule
